// ===== hdl/mvmac_pkg.sv =====
// shared types and constants for the matrix-vector multiply-accumulate core
package mvmac_pkg;

    // fixed field widths of the transaction ports
    localparam int INDEX_W     = 9;
    localparam int SUM_W       = 48;
    localparam int CHANNEL_W   = 6;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int LEN_FIELD_W = 10;
    localparam int NCH_FIELD_W = 7;

    // parameter defaults
    localparam int DEF_MAX_INPUT_LENGTH = 512;
    localparam int DEF_MAX_CHANNELS     = 64;
    localparam int DEF_VALUE_WIDTH      = 16;

    // register reset values before clamping
    localparam int LEN_RESET_RAW = 512;
    localparam int NCH_RESET_RAW = 64;

    typedef enum logic {
        KIND_WEIGHT     = 1'b0,
        KIND_ACTIVATION = 1'b1
    } t_kind;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_INPUT_LENGTH       = 2'd0,
        CFG_OUTPUT_CHANNELS    = 2'd1,
        CFG_WEIGHTS_TRANSPOSED = 2'd2
    } t_cfg_index;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic wr_en;   // weight write, cell checks its channel
        logic rd_en;   // read weight row of the current value
        logic mac_en;  // multiply activation by weight
        logic acc_en;  // add product into accumulator
        logic last;    // product belongs to the final value of the image
        logic shift;   // move result chain one cell toward the output
    } t_cell_ctl;

endpackage

// ===== hdl/mvmac_cell.sv =====
// one output channel: weight column memory, multiplier, accumulator, result chain stage
module mvmac_cell
    import mvmac_pkg::*;
#(
    parameter int MAX_INPUT_LENGTH = DEF_MAX_INPUT_LENGTH,
    parameter int MAX_CHANNELS     = DEF_MAX_CHANNELS,
    parameter int VALUE_WIDTH      = DEF_VALUE_WIDTH,
    parameter int CELL_INDEX       = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cell_ctl                     i_ctl,
    input  logic [((MAX_INPUT_LENGTH > 1) ? $clog2(MAX_INPUT_LENGTH) : 1)-1:0] i_wr_addr,
    input  logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0]         i_wr_channel,
    input  logic signed [VALUE_WIDTH-1:0] i_wr_data,
    input  logic [((MAX_INPUT_LENGTH > 1) ? $clog2(MAX_INPUT_LENGTH) : 1)-1:0] i_rd_addr,
    input  logic signed [VALUE_WIDTH-1:0] i_act,
    input  logic [$clog2(MAX_CHANNELS + 1)-1:0] i_nch,
    input  logic signed [SUM_W-1:0]       i_chain,
    output logic signed [SUM_W-1:0]       o_chain
);

    localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CW  = $clog2(MAX_CHANNELS + 1);
    localparam int PRW = 2 * VALUE_WIDTH;

    logic signed [VALUE_WIDTH-1:0] r_mem [MAX_INPUT_LENGTH];
    logic signed [VALUE_WIDTH-1:0] r_wt;
    logic signed [PRW-1:0]         r_prod;
    logic signed [SUM_W-1:0]       r_acc;
    logic signed [SUM_W-1:0]       r_chain;
    logic signed [SUM_W-1:0]       n_acc;
    logic                          w_active;
    logic                          w_wr_hit;

    assign w_active = (CW'(CELL_INDEX) < i_nch);
    assign w_wr_hit = i_ctl.wr_en && (i_wr_channel == CHW'(CELL_INDEX));
    // products wrap modulo the accumulator width
    assign n_acc    = r_acc + SUM_W'(r_prod);

    // weight column and multiplier, payload only
    always_ff @(posedge i_clk) begin
        if (w_wr_hit) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_wt <= r_mem[i_rd_addr];
        end
        if (i_ctl.mac_en) begin
            r_prod <= i_act * r_wt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            if (i_ctl.last) begin
                r_acc <= '0;
            end else if (w_active) begin
                r_acc <= n_acc;
            end
        end
    end

    // result chain, loaded at image end and shifted toward cell zero
    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_en && i_ctl.last) begin
            r_chain <= n_acc;
        end else if (i_ctl.shift) begin
            r_chain <= i_chain;
        end
    end

    assign o_chain = r_chain;

endmodule

// ===== hdl/matrix_vector_multiply_accumulate_core.sv =====
// top level of the fully connected layer core: sequencer and row of channel cells
//
// usage
// - input channel: a transaction is taken at a clock edge with i_start high and o_busy low
// - i_kind selects a weight write or an activation value of the current image
// - weight writes go into the weight column of the addressed channel cell; indexes swap
//   when weights_transposed is set, writes outside the store are dropped
// - activation values stream in one per cycle while o_busy is low; each is multiplied by its
//   weight row in every active channel cell and added into that cell's accumulator
// - results start once the final value of an image has passed the weight read, multiply
//   and accumulate steps, then one result per cycle on o_valid, channel 0 first, o_last on
//   the final channel
// - throughput: one transaction per cycle inside an image; at image end o_busy stays
//   high while the final value passes the pipeline and the result chain drains
// - the result chain is set by the cell row: each cell hands its sum to its neighbor
// - the receiver cannot stall: every result is shown for exactly one cycle
// - configuration writes via i_cfg_we / i_cfg_index / i_cfg_data, only while idle
// - reset: accumulators, value position, drain state and registers return to their
//   defaults; the weight store keeps its contents and is undefined until written
module matrix_vector_multiply_accumulate_core
    import mvmac_pkg::*;
#(
    parameter int MAX_INPUT_LENGTH = DEF_MAX_INPUT_LENGTH,
    parameter int MAX_CHANNELS     = DEF_MAX_CHANNELS,
    parameter int VALUE_WIDTH      = DEF_VALUE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input transaction
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_kind,
    input  logic [INDEX_W-1:0]            i_first_index,
    input  logic [INDEX_W-1:0]            i_second_index,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    // result transaction
    output logic                          o_valid,
    output logic [CHANNEL_W-1:0]          o_channel,
    output logic signed [SUM_W-1:0]       o_sum,
    output logic                          o_last
);

    localparam int PW  = (MAX_INPUT_LENGTH > 1) ? $clog2(MAX_INPUT_LENGTH) : 1;
    localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int LW  = $clog2(MAX_INPUT_LENGTH + 1);
    localparam int CW  = $clog2(MAX_CHANNELS + 1);
    localparam int LEN_RESET = (LEN_RESET_RAW > MAX_INPUT_LENGTH) ? MAX_INPUT_LENGTH
                                                                   : LEN_RESET_RAW;
    localparam int NCH_RESET = (NCH_RESET_RAW > MAX_CHANNELS) ? MAX_CHANNELS
                                                               : NCH_RESET_RAW;

    // configuration, stored already clamped
    logic [LW-1:0]  r_len;
    logic [CW-1:0]  r_nch;
    logic           r_trans;
    logic [LW-1:0]  n_len;
    logic [CW-1:0]  n_nch;

    // sequencer state
    logic [PW-1:0]  r_pos;
    logic           r_s1_valid;
    logic           r_s1_last;
    logic signed [VALUE_WIDTH-1:0] r_s1_value;
    logic           r_s2_valid;
    logic           r_s2_last;
    logic           r_drain;
    logic [CHW-1:0] r_cnt;

    logic           w_accept;
    logic           w_act;
    logic           w_end;
    logic           w_out_last;
    logic [INDEX_W-1:0] w_vi;
    logic [INDEX_W-1:0] w_ch;
    logic           w_wr_ok;
    t_cell_ctl      w_ctl;

    logic signed [SUM_W-1:0] w_chain_out [MAX_CHANNELS];
    logic signed [SUM_W-1:0] w_chain_in  [MAX_CHANNELS];

    // hold off new transactions while an image end is in flight or draining
    assign o_busy   = r_drain || (r_s1_valid && r_s1_last) || (r_s2_valid && r_s2_last);
    assign w_accept = i_start && !o_busy;
    assign w_act    = w_accept && (i_kind == KIND_ACTIVATION);
    // a lowered length ends the image on the next value
    assign w_end    = ((LW'(r_pos) + LW'(1)) >= r_len);

    // weight write address decode, transposed swaps the two index fields
    assign w_vi    = r_trans ? i_second_index : i_first_index;
    assign w_ch    = r_trans ? i_first_index  : i_second_index;
    assign w_wr_ok = (32'(w_vi) < MAX_INPUT_LENGTH) && (32'(w_ch) < MAX_CHANNELS);

    always_comb begin
        w_ctl        = '0;
        w_ctl.wr_en  = w_accept && (i_kind == KIND_WEIGHT) && w_wr_ok;
        w_ctl.rd_en  = w_act;
        w_ctl.mac_en = r_s1_valid;
        w_ctl.acc_en = r_s2_valid;
        w_ctl.last   = r_s2_last;
        w_ctl.shift  = r_drain;
    end

    // register clamping: zero acts as one, above the maximum acts as the maximum
    always_comb begin
        if (i_cfg_data == '0) begin
            n_len = LW'(1);
        end else if (32'(i_cfg_data[LEN_FIELD_W-1:0]) > MAX_INPUT_LENGTH) begin
            n_len = LW'(MAX_INPUT_LENGTH);
        end else begin
            n_len = LW'(i_cfg_data[LEN_FIELD_W-1:0]);
        end
        if (i_cfg_data[NCH_FIELD_W-1:0] == '0) begin
            n_nch = CW'(1);
        end else if (32'(i_cfg_data[NCH_FIELD_W-1:0]) > MAX_CHANNELS) begin
            n_nch = CW'(MAX_CHANNELS);
        end else begin
            n_nch = CW'(i_cfg_data[NCH_FIELD_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LW'(LEN_RESET);
            r_nch   <= CW'(NCH_RESET);
            r_trans <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INPUT_LENGTH:       r_len   <= n_len;
                CFG_OUTPUT_CHANNELS:    r_nch   <= n_nch;
                CFG_WEIGHTS_TRANSPOSED: r_trans <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // value position and the three-stage value pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s2_last  <= 1'b0;
        end else begin
            if (w_act) begin
                r_pos <= w_end ? '0 : (r_pos + PW'(1));
            end
            r_s1_valid <= w_act;
            r_s1_last  <= w_act && w_end;
            r_s2_valid <= r_s1_valid;
            r_s2_last  <= r_s1_valid && r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_act) begin
            r_s1_value <= i_value;
        end
    end

    assign w_out_last = ((CW'(r_cnt) + CW'(1)) == r_nch);

    // result drain, one channel per cycle out of cell zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain <= 1'b0;
            r_cnt   <= '0;
        end else if (r_s2_valid && r_s2_last) begin
            r_drain <= 1'b1;
            r_cnt   <= '0;
        end else if (r_drain) begin
            if (w_out_last) begin
                r_drain <= 1'b0;
            end
            r_cnt <= r_cnt + CHW'(1);
        end
    end

    // row of channel cells, result chain runs toward cell zero
    for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_cell
        if (c == MAX_CHANNELS - 1) begin : g_tail
            assign w_chain_in[c] = '0;
        end else begin : g_link
            assign w_chain_in[c] = w_chain_out[c+1];
        end

        mvmac_cell #(
            .MAX_INPUT_LENGTH (MAX_INPUT_LENGTH),
            .MAX_CHANNELS     (MAX_CHANNELS),
            .VALUE_WIDTH      (VALUE_WIDTH),
            .CELL_INDEX       (c)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_wr_addr    (PW'(w_vi)),
            .i_wr_channel (CHW'(w_ch)),
            .i_wr_data    (i_value),
            .i_rd_addr    (r_pos),
            .i_act        (r_s1_value),
            .i_nch        (r_nch),
            .i_chain      (w_chain_in[c]),
            .o_chain      (w_chain_out[c])
        );
    end

    assign o_valid   = r_drain;
    assign o_channel = CHANNEL_W'(r_cnt);
    assign o_sum     = w_chain_out[0];
    assign o_last    = r_drain && w_out_last;

    // the drain stops right after the final channel
    a_last_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result strobe continued after last channel");

    // the final value of an image starts the result drain after the read, multiply and accumulate steps
    a_end_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_act && w_end) |-> ##3 o_valid)
        else $error("image end did not start the result drain");

    // results only come while the input side is held off
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy)
        else $error("result strobe while input accepted");

    // every drain starts at channel zero
    a_first_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_channel == '0))
        else $error("drain did not start at channel zero");

endmodule

// ===== test/tb_matrix_vector_multiply_accumulate_core.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the fully connected layer core: weight writes, images, results
module tb_matrix_vector_multiply_accumulate_core;
    import mvmac_pkg::*;

    localparam int     MAX_LEN       = DEF_MAX_INPUT_LENGTH;
    localparam int     MAX_CH        = DEF_MAX_CHANNELS;
    localparam int     VAL_W         = DEF_VALUE_WIDTH;
    localparam int     STORE_DEPTH   = MAX_LEN * MAX_CH;
    localparam int     RANDOM_VALUES = 150;
    // wider images in the random part stay this short, their weight rows are written early
    localparam int     WIDE_MAX_LEN  = 2;
    localparam int     NARROW_MAX_CH = 4;
    // extra wait once the core is idle, a margin for weight writes before a register write
    localparam int     SETTLE_CYCLES = 8;
    localparam longint CYCLE_LIMIT   = 400000;
    localparam int     PRINT_LIMIT   = 100;
    // register index with no register behind it, writes must be dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic signed [VAL_W-1:0] VALUE_MAX = 16'sh7fff;
    localparam logic signed [VAL_W-1:0] VALUE_MIN = 16'sh8000;

    // one channel result of an image
    typedef struct packed {
        logic [CHANNEL_W-1:0] channel;
        logic [SUM_W-1:0]     sum;
        logic                 last;
    } t_channel_result;

    // mirror of the weight store, channel accumulators and registers, plus the queue
    // of channel results still to come
    class dot_product_board;
        logic signed [VAL_W-1:0] weights [STORE_DEPTH];
        bit                      written [STORE_DEPTH];
        logic [SUM_W-1:0]        acc [MAX_CH];
        int unsigned             position;
        logic [LEN_FIELD_W-1:0]  len_raw;
        logic [NCH_FIELD_W-1:0]  nch_raw;
        bit                      transposed;
        t_channel_result         expected_sums [$];
        int                      mismatches;
        int                      results_seen;
        int                      images;

        function new();
            for (int c = 0; c < MAX_CH; c++) acc[c] = '0;
            position     = 0;
            len_raw      = LEN_FIELD_W'(LEN_RESET_RAW);
            nch_raw      = NCH_FIELD_W'(NCH_RESET_RAW);
            transposed   = 1'b0;
            mismatches   = 0;
            results_seen = 0;
            images       = 0;
        endfunction

        function int unsigned clamp_to(int unsigned v, int unsigned max);
            if (v == 0) return 1;
            if (v > max) return max;
            return v;
        endfunction

        function int unsigned eff_len();
            return clamp_to(len_raw, MAX_LEN);
        endfunction

        function int unsigned eff_nch();
            return clamp_to(nch_raw, MAX_CH);
        endfunction

        function int pending();
            return expected_sums.size();
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_INPUT_LENGTH:       len_raw = data[LEN_FIELD_W-1:0];
                CFG_OUTPUT_CHANNELS:    nch_raw = data[NCH_FIELD_W-1:0];
                CFG_WEIGHTS_TRANSPOSED: transposed = data[0];
                default: ;
            endcase
        endfunction

        // accepted input transaction: store a weight, or accumulate one value
        function void note_item(t_kind kind, logic [INDEX_W-1:0] first,
                                logic [INDEX_W-1:0] second, logic signed [VAL_W-1:0] value);
            int unsigned     row;
            int unsigned     ch;
            int unsigned     len;
            int unsigned     nch;
            longint          prod;
            t_channel_result res;
            len = eff_len();
            nch = eff_nch();
            if (kind == KIND_WEIGHT) begin
                row = transposed ? second : first;
                ch  = transposed ? first : second;
                if (row < MAX_LEN && ch < MAX_CH) begin
                    weights[row * MAX_CH + ch] = value;
                    written[row * MAX_CH + ch] = 1'b1;
                end
                return;
            end
            if (position < MAX_LEN) begin
                row = position * MAX_CH;
                for (int c = 0; c < nch; c++) begin
                    prod   = longint'(value) * longint'(weights[row + c]);
                    acc[c] = acc[c] + prod[SUM_W-1:0];
                end
            end
            position++;
            if (position >= len) begin
                for (int c = 0; c < nch; c++) begin
                    res.channel = CHANNEL_W'(c);
                    res.sum     = acc[c];
                    res.last    = (c + 1 == nch);
                    expected_sums.push_back(res);
                end
                for (int c = 0; c < MAX_CH; c++) acc[c] = '0;
                position = 0;
                images++;
            end
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_channel_result(logic [CHANNEL_W-1:0] ch, logic [SUM_W-1:0] sum,
                                  logic last);
            t_channel_result want;
            results_seen++;
            if (expected_sums.size() == 0) begin
                report($sformatf("result with nothing expected: channel %0d sum %0d",
                                 ch, $signed(sum)));
                return;
            end
            want = expected_sums.pop_front();
            if (ch !== want.channel)
                report($sformatf("channel %0d, expected %0d", ch, want.channel));
            if (sum !== want.sum)
                report($sformatf("channel %0d sum %0d, expected %0d",
                                 want.channel, $signed(sum), $signed(want.sum)));
            if (last !== want.last)
                report($sformatf("channel %0d last %0b, expected %0b",
                                 want.channel, last, want.last));
        endtask
    endclass

    // clock, reset and block inputs, all known from time zero
    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_start        = 1'b0;
    t_kind                   i_kind         = KIND_WEIGHT;
    logic [INDEX_W-1:0]      i_first_index  = '0;
    logic [INDEX_W-1:0]      i_second_index = '0;
    logic signed [VAL_W-1:0] i_value        = '0;
    logic                    i_cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data     = '0;
    logic                    o_busy;
    logic                    o_valid;
    logic [CHANNEL_W-1:0]    o_channel;
    logic signed [SUM_W-1:0] o_sum;
    logic                    o_last;

    dot_product_board board;
    bit               gaps_on     = 1'b1;
    int               accepted    = 0;
    longint           cycle_count = 0;

    matrix_vector_multiply_accumulate_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_kind         (i_kind),
        .i_first_index  (i_first_index),
        .i_second_index (i_second_index),
        .i_value        (i_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_channel      (o_channel),
        .o_sum          (o_sum),
        .o_last         (o_last)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog, far above the slowest correct run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, board.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // one process samples both channels at the rising edge: results are checked
    // against the queue, accepted input transactions feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) board.check_channel_result(o_channel, o_sum, o_last);
            if (i_start && !o_busy) begin
                board.note_item(i_kind, i_first_index, i_second_index, i_value);
                accepted++;
            end
        end
    end

    // mostly random Q8.8 values with the extremes and zero mixed in
    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return VALUE_MAX;
            1:       return VALUE_MIN;
            2:       return '0;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // drive one input transaction at the falling edge, optionally after a few idle
    // cycles, and return right after the rising edge that takes it
    task automatic send_item(input t_kind kind, input logic [INDEX_W-1:0] first,
                             input logic [INDEX_W-1:0] second,
                             input logic signed [VAL_W-1:0] value);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start        <= 1'b1;
        i_kind         <= kind;
        i_first_index  <= first;
        i_second_index <= second;
        i_value        <= value;
        do @(posedge i_clk); while (o_busy);
    endtask

    // activation value; the index fields are don't-care and get noise
    task automatic send_value(input logic signed [VAL_W-1:0] value);
        send_item(KIND_ACTIVATION, INDEX_W'($urandom), INDEX_W'($urandom), value);
    endtask

    // weight write by (value index, channel), index fields swapped when transposed
    task automatic write_weight(input int unsigned row, input int unsigned ch,
                                input logic signed [VAL_W-1:0] value);
        if (board.transposed) send_item(KIND_WEIGHT, INDEX_W'(ch), INDEX_W'(row), value);
        else                  send_item(KIND_WEIGHT, INDEX_W'(row), INDEX_W'(ch), value);
    endtask

    // random weight write: either dropped (channel outside the store) or an overwrite
    task automatic noise_write();
        int unsigned bad_ch;
        int unsigned idx;
        bad_ch = $urandom_range(MAX_CH, (1 << INDEX_W) - 1);
        idx    = $urandom_range(0, (1 << INDEX_W) - 1);
        if ($urandom_range(0, 1)) begin
            if (board.transposed) send_item(KIND_WEIGHT, INDEX_W'(bad_ch), INDEX_W'(idx),
                                            rand_value());
            else                  send_item(KIND_WEIGHT, INDEX_W'(idx), INDEX_W'(bad_ch),
                                            rand_value());
        end else begin
            write_weight($urandom_range(0, MAX_LEN - 1), $urandom_range(0, MAX_CH - 1),
                         rand_value());
        end
    endtask

    // write every weight an image of this size will read that has never been written
    task automatic ensure_weights(input int unsigned rows, input int unsigned chans);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < chans; c++)
                if (!board.written[r * MAX_CH + c]) write_weight(r, c, rand_value());
    endtask

    // stop sending, wait for every expected result and for the core to go idle
    task automatic settle();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (board.pending() != 0 || o_busy) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // register write, only ever issued once the core is idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        settle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_reg(idx, data);
    endtask

    initial begin
        int unsigned len_raw;
        int unsigned nch_raw;
        int unsigned len;
        int unsigned cut;
        int unsigned n_img;
        bit          broken;
        int          random_values;
        board = new();
        random_values = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        // only the length is set: channel count and index order keep their reset values
        write_reg(CFG_INPUT_LENGTH, CFG_DATA_W'(2));
        write_weight(0, 0, VALUE_MAX);
        write_weight(1, MAX_CH - 1, VALUE_MIN);
        ensure_weights(2, MAX_CH);
        send_value(VALUE_MAX);
        send_value(VALUE_MIN);
        send_value('0);
        send_value(-16'sd1);

        // transposed writes: first field is the channel
        write_reg(CFG_WEIGHTS_TRANSPOSED, CFG_DATA_W'(1));
        send_item(KIND_WEIGHT, 9'd5, 9'd1, 16'sd256);
        // channel 511 lies outside the store, dropped
        send_item(KIND_WEIGHT, 9'd511, 9'd0, 16'sd1234);
        send_value(16'sd256);
        send_value(16'sd512);

        // normal order again: channel 64 dropped, top corner of the store written
        write_reg(CFG_WEIGHTS_TRANSPOSED, CFG_DATA_W'(0));
        send_item(KIND_WEIGHT, 9'd0, 9'd64, VALUE_MAX);
        send_item(KIND_WEIGHT, 9'd511, 9'd63, VALUE_MIN);

        // zero in both size registers acts as one
        write_reg(CFG_INPUT_LENGTH, CFG_DATA_W'(0));
        write_reg(CFG_OUTPUT_CHANNELS, CFG_DATA_W'(0));
        send_value(VALUE_MIN);

        // length above the maximum saturates: the image runs on until the length drops
        write_reg(CFG_INPUT_LENGTH, CFG_DATA_W'(1023));
        write_reg(CFG_OUTPUT_CHANNELS, CFG_DATA_W'(1));
        ensure_weights(4, 1);
        repeat (3) send_value(rand_value());
        write_reg(CFG_INPUT_LENGTH, CFG_DATA_W'(1));
        send_value(rand_value());

        // channel count above the maximum saturates to all channels
        write_reg(CFG_INPUT_LENGTH, CFG_DATA_W'(1));
        write_reg(CFG_OUTPUT_CHANNELS, CFG_DATA_W'(127));
        send_value(VALUE_MAX);

        // length lowered below the current position: image ends on the next value
        write_reg(CFG_INPUT_LENGTH, CFG_DATA_W'(6));
        write_reg(CFG_OUTPUT_CHANNELS, CFG_DATA_W'(3));
        ensure_weights(6, 5);
        repeat (4) send_value(rand_value());
        write_reg(CFG_INPUT_LENGTH, CFG_DATA_W'(2));
        send_value(rand_value());

        // channel count raised mid-image: new channels only see the later values
        write_reg(CFG_INPUT_LENGTH, CFG_DATA_W'(4));
        write_reg(CFG_OUTPUT_CHANNELS, CFG_DATA_W'(2));
        repeat (2) send_value(rand_value());
        write_reg(CFG_OUTPUT_CHANNELS, CFG_DATA_W'(5));
        repeat (2) send_value(rand_value());

        // ---- random part: phases of one setting each, a few images per phase ----
        while (random_values < RANDOM_VALUES) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 7))
                0:       nch_raw = 0;
                1:       nch_raw = $urandom_range(MAX_CH + 1, 127);
                2:       nch_raw = MAX_CH;
                3:       nch_raw = $urandom_range(1, NARROW_MAX_CH);
                default: nch_raw = $urandom_range(1, MAX_CH);
            endcase
            // wide images stay short so the weight rows written above already cover them
            if (board.clamp_to(nch_raw, MAX_CH) > NARROW_MAX_CH) begin
                len_raw = $urandom_range(0, WIDE_MAX_LEN);
            end else begin
                case ($urandom_range(0, 9))
                    0:       len_raw = 0;
                    1:       len_raw = $urandom_range(9, 12);
                    default: len_raw = $urandom_range(1, 8);
                endcase
            end
            // upper data bits beyond each register's width are junk and must be ignored
            write_reg(CFG_INPUT_LENGTH, CFG_DATA_W'(len_raw));
            write_reg(CFG_OUTPUT_CHANNELS, {3'($urandom), 7'(nch_raw)});
            write_reg(CFG_WEIGHTS_TRANSPOSED, {9'($urandom), 1'($urandom)});
            if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
            ensure_weights(board.eff_len(), board.eff_nch());
            n_img = $urandom_range(1, 4);
            for (int img = 0; img < n_img; img++) begin
                len    = board.eff_len();
                broken = (len > 1) && ($urandom_range(0, 5) == 0);
                cut    = broken ? $urandom_range(1, len - 1) : len;
                for (int k = 0; k < cut; k++) begin
                    if ($urandom_range(0, 4) == 0) noise_write();
                    send_value(rand_value());
                    random_values++;
                end
                // cut image short by lowering the length to at most the position
                if (broken) begin
                    write_reg(CFG_INPUT_LENGTH, CFG_DATA_W'($urandom_range(1, cut)));
                    send_value(rand_value());
                    random_values++;
                end
            end
        end

        settle();
        $display("covered %0d input transactions, %0d images, %0d channel results checked",
                 accepted, board.images, board.results_seen);
        $display("%0d mismatches, %0d results left unmatched",
                 board.mismatches, board.pending());
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/mvmac_pkg.sv
hdl/mvmac_cell.sv
hdl/matrix_vector_multiply_accumulate_core.sv
test/tb_matrix_vector_multiply_accumulate_core.sv
